// File: rtl/lcc_reliability_ordering_core_defines.svh
// ----------------------------------------------------------------------------
// LCC reliability ordering assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LCC_RELIABILITY_ORDERING_CORE_DEFINES_SVH
`define LCC_RELIABILITY_ORDERING_CORE_DEFINES_SVH

// same-cycle implication
`define LCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Widths, word types and the GF(16) power table for the reliability sorter.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int CODE_LENGTH = 15;
    localparam int POS_W       = 4;
    localparam int SYM_W       = 4;
    localparam int REL_W       = 16;
    localparam int GF_W        = 4;
    localparam int RANK_W      = 4;
    localparam int TPC_W       = 3;
    localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
    localparam int PROD_W      = 2 * REL_W;
    localparam int SUM_W       = RANK_W + 1;

    localparam int S_FIELDS_W  = POS_W + SYM_W + REL_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = RANK_W + POS_W + 2 * SYM_W + GF_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    typedef struct packed {
        logic [REL_W-1:0] num;
        logic [REL_W-1:0] den;
        logic [POS_W-1:0] pos;
        logic [SYM_W-1:0] hsym;
        logic [SYM_W-1:0] ssym;
    } t_item;

    typedef struct packed {
        logic flush;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic             wr;
        logic             clear;
        logic [POS_W-1:0] pos;
        logic [SYM_W-1:0] sym;
        logic [REL_W-1:0] rel;
    } t_store_req;

    function automatic logic [GF_W-1:0] alpha_pow(input logic [POS_W-1:0] p);
        logic [GF_W-1:0] v;
        case (p)
            4'd0:    v = 4'd1;
            4'd1:    v = 4'd2;
            4'd2:    v = 4'd4;
            4'd3:    v = 4'd8;
            4'd4:    v = 4'd3;
            4'd5:    v = 4'd6;
            4'd6:    v = 4'd12;
            4'd7:    v = 4'd11;
            4'd8:    v = 4'd5;
            4'd9:    v = 4'd10;
            4'd10:   v = 4'd7;
            4'd11:   v = 4'd14;
            4'd12:   v = 4'd15;
            4'd13:   v = 4'd13;
            4'd14:   v = 4'd9;
            default: v = 4'd1;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/lcc_store.sv
// ----------------------------------------------------------------------------
// lcc_store
// Per-position best and second reliabilities with their symbols; one read port
// that presents a position as a ratio word for the sort chain.
// ----------------------------------------------------------------------------
module lcc_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lcc_pkg::t_store_req    i_req,
    input  logic [lcc_pkg::POS_W-1:0] i_rd_pos,
    output lcc_pkg::t_item         o_rd_item
);
    import lcc_pkg::*;

    logic [REL_W-1:0] r_best   [CODE_LENGTH];
    logic [REL_W-1:0] r_second [CODE_LENGTH];
    logic [SYM_W-1:0] r_bsym   [CODE_LENGTH];
    logic [SYM_W-1:0] r_rsym   [CODE_LENGTH];

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < CODE_LENGTH; e++) begin
            if (!i_rst_n || i_req.clear) begin
                r_best[e]   <= '0;
                r_second[e] <= '0;
                r_bsym[e]   <= '0;
                r_rsym[e]   <= '0;
            end else if (i_req.wr && (i_req.pos == POS_W'(e))) begin
                if (i_req.rel > r_best[e]) begin
                    r_second[e] <= r_best[e];
                    r_rsym[e]   <= r_bsym[e];
                    r_best[e]   <= i_req.rel;
                    r_bsym[e]   <= i_req.sym;
                end else if (i_req.rel > r_second[e]) begin
                    r_second[e] <= i_req.rel;
                    r_rsym[e]   <= i_req.sym;
                end
            end
        end
    end

    always_comb begin
        o_rd_item.pos = i_rd_pos;
        if (r_best[i_rd_pos] == '0) begin
            o_rd_item.num  = REL_W'(1);
            o_rd_item.den  = REL_W'(1);
            o_rd_item.hsym = '0;
            o_rd_item.ssym = '0;
        end else begin
            o_rd_item.num  = r_second[i_rd_pos];
            o_rd_item.den  = r_best[i_rd_pos];
            o_rd_item.hsym = r_bsym[i_rd_pos];
            o_rd_item.ssym = r_rsym[i_rd_pos];
        end
    end

endmodule

// File: rtl/lcc_cell.sv
// ----------------------------------------------------------------------------
// lcc_cell
// One insertion-sort cell: keep the word that ranks first, pass the other on;
// shift left towards the chain head as results are taken; empty during load.
// ----------------------------------------------------------------------------
module lcc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcc_pkg::t_cell_ctl i_ctl,
    input  logic               i_in_v,
    input  lcc_pkg::t_item     i_in,
    input  logic               i_right_v,
    input  lcc_pkg::t_item     i_right,
    output logic               o_held_v,
    output lcc_pkg::t_item     o_held,
    output logic               o_pass_v,
    output lcc_pkg::t_item     o_pass
);
    import lcc_pkg::*;

    logic              r_held_v, n_held_v;
    logic              r_pass_v, n_pass_v;
    t_item             r_held, n_held;
    t_item             r_pass, n_pass;
    logic [PROD_W-1:0] w_lhs, w_rhs;
    logic              w_before;

    assign w_lhs    = PROD_W'(i_in.num) * PROD_W'(r_held.den);
    assign w_rhs    = PROD_W'(r_held.num) * PROD_W'(i_in.den);
    assign w_before = (w_lhs < w_rhs) || ((w_lhs == w_rhs) && (i_in.pos < r_held.pos));

    always_comb begin
        n_held_v = r_held_v;
        n_held   = r_held;
        n_pass_v = 1'b0;
        n_pass   = r_pass;
        if (i_ctl.flush) begin
            n_held_v = 1'b0;
        end else if (i_ctl.shift) begin
            n_held_v = i_right_v;
            n_held   = i_right;
        end else if (i_in_v) begin
            if (!r_held_v) begin
                n_held_v = 1'b1;
                n_held   = i_in;
            end else if (w_before) begin
                n_held   = i_in;
                n_pass_v = 1'b1;
                n_pass   = r_held;
            end else begin
                n_pass_v = 1'b1;
                n_pass   = i_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_pass_v <= 1'b0;
        end else begin
            r_held_v <= n_held_v;
            r_pass_v <= n_pass_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_pass <= n_pass;
    end

    assign o_held_v = r_held_v;
    assign o_held   = r_held;
    assign o_pass_v = r_pass_v;
    assign o_pass   = r_pass;

endmodule

// File: rtl/lcc_reliability_ordering_core.sv
// ----------------------------------------------------------------------------
// lcc_reliability_ordering_core
// LCC front end: collect best/second reliabilities per position and emit
// positions in ascending second/best ratio order, flagging test positions.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   i_s_tdata, i_s_tlast
// m         out  o_m_tvalid / i_m_tready   o_m_tdata, o_m_tuser, o_m_tlast
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data
//
// Matrix words load at one per cycle while o_s_tready is high. After the
// tlast word, FEED reads the positions into the 15-cell insertion chain,
// DRAIN lets it settle, then 15 results leave, one per cycle when m is ready.
// o_s_tready is low from the tlast word until the final result is taken.
// Reset is synchronous: store zeroed, chain empty, test count 2.
// ----------------------------------------------------------------------------
`include "lcc_reliability_ordering_core_defines.svh"

module lcc_reliability_ordering_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // position [3:0], symbol [7:4], reliability [23:8]
    input  logic [lcc_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tlast,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // rank [3:0], ranked_position [7:4], hard_symbol [11:8],
    // second_symbol [15:12], eval_point [19:16], zero fill above
    output logic [lcc_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // is_test_position [0]
    output logic                           o_m_tuser,
    output logic                           o_m_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lcc_pkg::TPC_W-1:0]      i_cfg_data
);
    import lcc_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_FEED  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [TPC_W-1:0] r_tpc;
    logic             r_feed_v;
    t_item            r_feed;

    logic             w_s_acc, w_m_acc;
    t_store_req       w_req;
    t_item            w_rd_item;
    t_cell_ctl        w_ctl;
    logic             w_held_v [CODE_LENGTH];
    t_item            w_held   [CODE_LENGTH];
    logic             w_pass_v [CODE_LENGTH];
    t_item            w_pass   [CODE_LENGTH];
    logic [SUM_W-1:0] w_sum;

    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_m_acc     = o_m_tvalid && i_m_tready;
    assign o_s_tready  = (r_state == ST_LOAD);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_req.wr    = w_s_acc;
        w_req.clear = (r_state == ST_FEED) && (r_cnt == CNT_W'(CODE_LENGTH - 1));
        w_req.pos   = i_s_tdata[POS_W-1:0];
        w_req.sym   = i_s_tdata[POS_W +: SYM_W];
        w_req.rel   = i_s_tdata[POS_W+SYM_W +: REL_W];
    end

    lcc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_rd_pos  (r_cnt[POS_W-1:0]),
        .o_rd_item (w_rd_item)
    );

    always_comb begin
        w_ctl.flush = (r_state == ST_LOAD);
        w_ctl.shift = w_m_acc;
    end

    for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_chain
        logic  w_in_v, w_right_v;
        t_item w_in, w_right;
        if (g == 0) begin : g_head
            assign w_in_v = r_feed_v;
            assign w_in   = r_feed;
        end else begin : g_body
            assign w_in_v = w_pass_v[g-1];
            assign w_in   = w_pass[g-1];
        end
        if (g == CODE_LENGTH - 1) begin : g_tail
            assign w_right_v = 1'b0;
            assign w_right   = '0;
        end else begin : g_next
            assign w_right_v = w_held_v[g+1];
            assign w_right   = w_held[g+1];
        end
        lcc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_in_v    (w_in_v),
            .i_in      (w_in),
            .i_right_v (w_right_v),
            .i_right   (w_right),
            .o_held_v  (w_held_v[g]),
            .o_held    (w_held[g]),
            .o_pass_v  (w_pass_v[g]),
            .o_pass    (w_pass[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rank  = r_rank;
        case (r_state)
            ST_LOAD: begin
                if (w_s_acc && i_s_tlast) begin
                    n_state = ST_FEED;
                    n_cnt   = '0;
                end
            end
            ST_FEED: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CODE_LENGTH - 1)) begin
                    n_state = ST_DRAIN;
                    n_cnt   = '0;
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CODE_LENGTH)) begin
                    n_state = ST_OUT;
                    n_rank  = '0;
                end
            end
            ST_OUT: begin
                if (w_m_acc) begin
                    n_rank = r_rank + RANK_W'(1);
                    if (r_rank == RANK_W'(CODE_LENGTH - 1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_rank   <= '0;
            r_tpc    <= TPC_W'(2);
            r_feed_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rank   <= n_rank;
            r_feed_v <= (r_state == ST_FEED);
            if (i_cfg_valid) begin
                r_tpc <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_feed <= w_rd_item;
    end

    assign w_sum      = SUM_W'(r_rank) + SUM_W'(r_tpc);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tuser  = (w_sum >= SUM_W'(CODE_LENGTH));
    assign o_m_tlast  = (r_rank == RANK_W'(CODE_LENGTH - 1));
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, alpha_pow(w_held[0].pos), w_held[0].ssym,
                         w_held[0].hsym, w_held[0].pos, r_rank};

    `LCC_ASSERT_IMP(a_no_load_while_out, o_m_tvalid, !o_s_tready, "input open during output")
    `LCC_ASSERT_IMP(a_head_valid, o_m_tvalid, w_held_v[0], "chain head empty during output")
    `LCC_ASSERT_NXT(a_last_starts_feed, w_s_acc && i_s_tlast, (r_state == ST_FEED) && (r_cnt == '0), "tlast did not start feed")
    `LCC_ASSERT_NXT(a_end_returns_load, w_m_acc && o_m_tlast, r_state == ST_LOAD, "final word did not reopen input")
    `LCC_ASSERT_IMP(a_settled_on_out, o_m_tvalid, !w_pass_v[CODE_LENGTH-1], "chain overflow")

endmodule

// File: bench/lcc_ordering_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcc_ordering_checker
// Watches the matrix, ranked-result and count channels of the reliability
// sorter. Keeps its own per-position best/second store, ranks the positions
// on each tlast word by cross-multiplied ratio, queues the fifteen ranked
// words and compares every word taken from the block against the oldest one.
// ----------------------------------------------------------------------------
module lcc_ordering_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lcc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tlast,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [lcc_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                          i_m_tuser,
    input  logic                          i_m_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [lcc_pkg::TPC_W-1:0]     i_cfg_data,
    output int                            o_mismatch_count,
    output int                            o_pending
);
    import lcc_pkg::*;

    // alpha^p for p = 0..14, lowest nibble first
    localparam logic [4*CODE_LENGTH-1:0] EVAL_TABLE = {
        4'd9, 4'd13, 4'd15, 4'd14, 4'd7, 4'd10, 4'd5, 4'd11,
        4'd12, 4'd6, 4'd3, 4'd8, 4'd4, 4'd2, 4'd1
    };

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [POS_W-1:0]  position;
        logic [SYM_W-1:0]  hard_sym;
        logic [SYM_W-1:0]  second_sym;
        logic [GF_W-1:0]   eval_pt;
        logic              test_pos;
        logic              end_of_list;
    } t_ranked_word;

    logic [REL_W-1:0] best_rel [CODE_LENGTH];
    logic [REL_W-1:0] second_rel [CODE_LENGTH];
    logic [SYM_W-1:0] best_sym [CODE_LENGTH];
    logic [SYM_W-1:0] runner_sym [CODE_LENGTH];
    logic [TPC_W-1:0] test_count;
    t_ranked_word     ranked_q [$];
    int               mismatches = 0;
    int               pending = 0;

    assign o_mismatch_count = mismatches;
    assign o_pending        = pending;

    task automatic clear_store();
        int i;
        for (i = 0; i < CODE_LENGTH; i++) begin
            best_rel[i]   = '0;
            second_rel[i] = '0;
            best_sym[i]   = '0;
            runner_sym[i] = '0;
        end
    endtask

    // true if position a ranks ahead of position b
    function automatic bit ranks_ahead(int a, int b);
        longint unsigned na, da, nb, db, lhs, rhs;
        if (best_rel[a] == 0) begin
            na = 1;
            da = 1;
        end else begin
            na = second_rel[a];
            da = best_rel[a];
        end
        if (best_rel[b] == 0) begin
            nb = 1;
            db = 1;
        end else begin
            nb = second_rel[b];
            db = best_rel[b];
        end
        lhs = na * db;
        rhs = nb * da;
        if (lhs != rhs) return lhs < rhs;
        return a < b;
    endfunction

    task automatic absorb_word();
        logic [POS_W-1:0] pos;
        logic [SYM_W-1:0] sym;
        logic [REL_W-1:0] rel;
        int               order [CODE_LENGTH];
        int               i, j, r, p;
        t_ranked_word     e;
        pos = i_s_tdata[3:0];
        sym = i_s_tdata[7:4];
        rel = i_s_tdata[23:8];
        if (pos < CODE_LENGTH) begin
            if (rel > best_rel[pos]) begin
                second_rel[pos] = best_rel[pos];
                runner_sym[pos] = best_sym[pos];
                best_rel[pos]   = rel;
                best_sym[pos]   = sym;
            end else if (rel > second_rel[pos]) begin
                second_rel[pos] = rel;
                runner_sym[pos] = sym;
            end
        end
        if (i_s_tlast) begin
            for (i = 0; i < CODE_LENGTH; i++) begin
                r = 0;
                for (j = 0; j < CODE_LENGTH; j++)
                    if (j != i && ranks_ahead(j, i)) r++;
                order[r] = i;
            end
            for (i = 0; i < CODE_LENGTH; i++) begin
                p = order[i];
                e.rank        = RANK_W'(i);
                e.position    = POS_W'(p);
                e.hard_sym    = (best_rel[p] == 0) ? '0 : best_sym[p];
                e.second_sym  = (best_rel[p] == 0) ? '0 : runner_sym[p];
                e.eval_pt     = EVAL_TABLE[p*4 +: 4];
                e.test_pos    = (i + int'(test_count)) >= CODE_LENGTH;
                e.end_of_list = (i == CODE_LENGTH - 1);
                ranked_q.push_back(e);
            end
            clear_store();
        end
    endtask

    task automatic check_result();
        t_ranked_word a, e;
        logic         pad_bad;
        a.rank        = i_m_tdata[3:0];
        a.position    = i_m_tdata[7:4];
        a.hard_sym    = i_m_tdata[11:8];
        a.second_sym  = i_m_tdata[15:12];
        a.eval_pt     = i_m_tdata[19:16];
        a.test_pos    = i_m_tuser;
        a.end_of_list = i_m_tlast;
        pad_bad       = (i_m_tdata[M_TDATA_W-1:20] !== '0);
        if (ranked_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected word rank=%0d pos=%0d", $realtime,
                         a.rank, a.position);
        end else begin
            e = ranked_q.pop_front();
            if (a !== e || pad_bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch exp rank=%0d pos=%0d hard=%0d sec=%0d ",
                              "eval=%0d test=%0d eol=%0d | got rank=%0d pos=%0d ",
                              "hard=%0d sec=%0d eval=%0d test=%0d eol=%0d pad=%0d"},
                             $realtime, e.rank, e.position, e.hard_sym, e.second_sym,
                             e.eval_pt, e.test_pos, e.end_of_list, a.rank, a.position,
                             a.hard_sym, a.second_sym, a.eval_pt, a.test_pos,
                             a.end_of_list, pad_bad);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_store();
            test_count = TPC_W'(2);
            ranked_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) test_count = i_cfg_data;
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_s_tvalid && i_s_tready) absorb_word();
        end
        pending = ranked_q.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LCC reliability sorter: directed matrices for ties, zero
// and out-of-range cases, then random matrices with random idle gaps on both
// sides, a long result hold-off and changes of the test position count.
// ----------------------------------------------------------------------------
module tb;
    import lcc_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TPC_W-1:0]     cfg_data = '0;
    int                   mismatch_count;
    int                   pending;
    bit                   s_idle_on = 1'b1;
    bit                   m_idle_on = 1'b1;
    bit                   hold_start = 1'b0;
    bit                   hold_off = 1'b0;
    int                   words_sent = 0;
    int                   frame_idx = 0;

    always #4 i_clk = ~i_clk;

    lcc_reliability_ordering_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    lcc_ordering_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tdata        (s_tdata),
        .i_s_tlast        (s_tlast),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .i_m_tlast        (m_tlast),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    // called at a falling edge, returns at a falling edge with tvalid still high
    task automatic send_word(int pos, int sym, int rel, bit last);
        int gap;
        gap = s_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= S_TDATA_W'({rel[15:0], sym[3:0], pos[3:0]});
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_test_count(int value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(negedge i_clk);
        cfg_data  <= TPC_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // zero, full scale, a small set that makes ratio ties likely, or anything
    function automatic int pick_rel();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            2: return 100 * $urandom_range(1, 4);
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    task automatic send_random_frame();
        int  n, k, pos, sym, cnt, j;
        bit  tidy;
        n    = $urandom_range(1, 20);
        tidy = ($urandom_range(0, 3) != 0);
        k    = 0;
        while (k < n) begin
            if (tidy) begin
                pos = $urandom_range(0, 14);
                cnt = $urandom_range(1, 4);
                sym = $urandom_range(0, 12);
                for (j = 0; j < cnt && k < n && sym <= 15; j++) begin
                    send_word(pos, sym, pick_rel(), k == n - 1);
                    k++;
                    sym += $urandom_range(1, 3);
                end
            end else begin
                send_word($urandom_range(0, 15), $urandom_range(0, 15), pick_rel(),
                          k == n - 1);
                k++;
            end
        end
    endtask

    // receiver: random ready gaps, held low while a hold-off is in force
    initial begin
        int gap;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            gap = m_idle_on ? $urandom_range(0, 19) : 0;
            if (gap > 0 || hold_off) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                while (hold_off) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        wait (hold_start);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all positions empty: every ratio one, order by position
        send_word(0, 0, 0, 1'b1);

        write_test_count(0);
        send_word(14, 15, 16'hFFFF, 1'b0);
        send_word(0, 3, 100, 1'b0);
        send_word(0, 5, 100, 1'b0);
        send_word(1, 2, 500, 1'b0);
        send_word(2, 7, 10, 1'b0);
        send_word(2, 9, 20, 1'b0);
        send_word(2, 1, 15, 1'b0);
        send_word(3, 4, 0, 1'b0);
        send_word(15, 8, 16'hFFFF, 1'b0);
        send_word(5, 0, 16'hFFFF, 1'b0);
        send_word(5, 1, 16'hFFFF, 1'b0);
        send_word(14, 15, 16'hFFFF, 1'b0);
        send_word(6, 10, 1, 1'b0);
        send_word(6, 11, 16'hFFFF, 1'b0);
        send_word(15, 0, 0, 1'b1);

        write_test_count(7);
        send_word(8, 6, 300, 1'b0);
        send_word(7, 15, 16'hFFFF, 1'b1);

        write_test_count(4);
        while (words_sent < 140) begin
            s_idle_on = ($urandom_range(0, 2) != 0);
            m_idle_on = ($urandom_range(0, 2) != 0);
            if (frame_idx == 2) begin
                // hold results back while two matrices are sent; their words wait on s_tready
                hold_start = 1'b1;
                send_random_frame();
                send_random_frame();
                s_tvalid <= 1'b0;
                wait_drained();
                @(negedge i_clk);
            end else begin
                send_random_frame();
            end
            if ($urandom_range(0, 2) == 0) write_test_count($urandom_range(0, 7));
            frame_idx++;
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
